@@ sv/mhpq_pkg.sv @@
// Shared types for the binary min-heap priority queue.
// No dependencies; imported by mhpq_core, min_heap_priority_queue, heap_order_checker and the testbench.
package mhpq_pkg;

  localparam int KeyW = 32;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_APPEND  = 2'd2,
    ACT_BUILD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic signed [KeyW-1:0]   min_key;
  } res_t;

endpackage

@@ sv/mhpq_core.sv @@
// Heap sequencer: key store, single-read-port memory and sift state machine.
// Depends on mhpq_pkg.
module mhpq_core import mhpq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  action_e                           action_i,
  input  logic signed [KeyW-1:0]            key_i,
  output logic                              ready_o,
  input  logic                              res_ready_i,
  output logic                              done_o,
  output res_t                              res_o,
  output logic [$clog2(CAPACITY+1)-1:0]     count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;   // child index width, no wrap at the last node

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_UP    = 11'b000_0000_0010,
    S_UPCMP = 11'b000_0000_0100,
    S_EXRD  = 11'b000_0000_1000,
    S_EXLD  = 11'b000_0001_0000,
    S_SDL   = 11'b000_0010_0000,
    S_SDR   = 11'b000_0100_0000,
    S_SDC   = 11'b000_1000_0000,
    S_BNEXT = 11'b001_0000_0000,
    S_BLD   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           bnode_q, bnode_d;
  logic [AW-1:0]           node_q, node_d;
  logic [AW-1:0]           bidx_q, bidx_d;
  logic signed [KeyW-1:0]  v_q, v_d;
  logic signed [KeyW-1:0]  bval_q, bval_d;
  logic                    bmv_q, bmv_d;
  logic                    hasr_q, hasr_d;
  action_e                 op_q, op_d;
  status_e                 st_q, st_d;
  logic signed [KeyW-1:0]  min_q, min_d;

  // store
  logic signed [KeyW-1:0]  mem [CAPACITY];
  logic signed [KeyW-1:0]  rdata_q;
  logic                    rd_en, we;
  logic [AW-1:0]           rd_addr, wa;
  logic signed [KeyW-1:0]  wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  logic [XW-1:0] cnt_x, left_x, right_x;
  logic [AW-1:0] parent;
  logic          full, sd_next_mv;
  logic [AW-1:0] sd_next_idx;
  logic signed [KeyW-1:0] sd_next_val;
  state_e        sd_exit;

  assign cnt_x   = XW'(cnt_q);
  assign left_x  = {1'b0, node_q, 1'b1};
  assign right_x = left_x + XW'(1);
  assign parent  = (node_q - AW'(1)) >> 1;
  assign full    = (cnt_q == CW'(CAPACITY));
  assign sd_exit = (op_q == ACT_BUILD) ? S_BNEXT : S_DONE;

  // right child against the pick made from the left child
  always_comb begin
    sd_next_mv  = bmv_q;
    sd_next_idx = bidx_q;
    sd_next_val = bval_q;
    if (hasr_q && (rdata_q < bval_q)) begin
      sd_next_mv  = 1'b1;
      sd_next_idx = right_x[AW-1:0];
      sd_next_val = rdata_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bnode_d = bnode_q;
    node_d  = node_q;
    bidx_d  = bidx_q;
    v_d     = v_q;
    bval_d  = bval_q;
    bmv_d   = bmv_q;
    hasr_d  = hasr_q;
    op_d    = op_q;
    st_d    = st_q;
    min_d   = min_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = node_q;
    wd      = v_q;
    done_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = action_i;
          st_d  = ST_OK;
          min_d = '0;
          case (action_i)
            ACT_INSERT: begin
              if (full) begin
                st_d    = ST_FULL;
                state_d = S_DONE;
              end else begin
                node_d  = cnt_q[AW-1:0];
                cnt_d   = cnt_q + CW'(1);
                v_d     = key_i;
                state_d = S_UP;
              end
            end
            ACT_EXTRACT: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                min_d   = -32'sd1;
                state_d = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = S_EXRD;
              end
            end
            ACT_APPEND: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                we    = 1'b1;
                wa    = cnt_q[AW-1:0];
                wd    = key_i;
                cnt_d = cnt_q + CW'(1);
              end
              state_d = S_DONE;
            end
            ACT_BUILD: begin
              if (cnt_q > CW'(1)) begin
                bnode_d = ((cnt_q - CW'(1)) >> 1) + CW'(1);
                state_d = S_BNEXT;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_UP: begin
        if (node_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        we = 1'b1;
        if (v_q < rdata_q) begin
          wd      = rdata_q;
          node_d  = parent;
          state_d = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EXRD: begin
        min_d   = rdata_q;
        rd_en   = 1'b1;
        rd_addr = AW'(cnt_q - CW'(1));
        state_d = S_EXLD;
      end
      S_EXLD: begin
        v_d     = rdata_q;
        cnt_d   = cnt_q - CW'(1);
        node_d  = '0;
        state_d = S_SDL;
      end
      S_SDL: begin
        if (left_x < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = left_x[AW-1:0];
          state_d = S_SDR;
        end else begin
          we      = 1'b1;
          state_d = sd_exit;
        end
      end
      S_SDR: begin
        if (rdata_q < v_q) begin
          bmv_d  = 1'b1;
          bidx_d = left_x[AW-1:0];
          bval_d = rdata_q;
        end else begin
          bmv_d  = 1'b0;
          bidx_d = node_q;
          bval_d = v_q;
        end
        hasr_d = (right_x < cnt_x);
        if (right_x < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = right_x[AW-1:0];
        end
        state_d = S_SDC;
      end
      S_SDC: begin
        we = 1'b1;
        if (sd_next_mv) begin
          wd      = sd_next_val;
          node_d  = sd_next_idx;
          state_d = S_SDL;
        end else begin
          state_d = sd_exit;
        end
      end
      S_BNEXT: begin
        if (bnode_q == '0) begin
          state_d = S_DONE;
        end else begin
          bnode_d = bnode_q - CW'(1);
          rd_en   = 1'b1;
          rd_addr = AW'(bnode_q - CW'(1));
          state_d = S_BLD;
        end
      end
      S_BLD: begin
        v_d     = rdata_q;
        node_d  = bnode_q[AW-1:0];
        state_d = S_SDL;
      end
      S_DONE: begin
        if (res_ready_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bnode_q <= bnode_d;
    node_q  <= node_d;
    bidx_q  <= bidx_d;
    v_q     <= v_d;
    bval_q  <= bval_d;
    bmv_q   <= bmv_d;
    hasr_q  <= hasr_d;
    op_q    <= op_d;
    st_q    <= st_d;
    min_q   <= min_d;
  end

  assign ready_o        = (state_q == S_IDLE);
  assign res_o.status   = st_q;
  assign res_o.min_key  = min_q;
  assign count_o        = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |=> $stable(cnt_q))
    else $error("entry count moved while idle");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == CW'($past(cnt_q) + CW'(1))) || ($past(cnt_q) == CW'(cnt_q + CW'(1)))))
    else $error("entry count jumped by more than one");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_EMPTY) |-> (res_o.min_key == -32'sd1 && cnt_q == '0))
    else $error("empty extract with bad key or count");

endmodule

@@ sv/min_heap_priority_queue.sv @@
// Binary min-heap priority queue, one result word per input word; uses mhpq_pkg, mhpq_core.
// Insert climbs toward the root; extract reads the root and the last entry, then sinks it;
// append and refused words go straight to the result; build sinks each node from index
// (count-1)/2 down to the root. One word in flight, tready returns with tvalid.
// Reset (rst_ni low, async) empties the heap and drops a pending word; store is not cleared.
module min_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input word
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [KeyW-1:0]              s_axis_tdata_i,  // [31:0] key
  input  logic [1:0]                   s_axis_tuser_i,  // [1:0] action
  // result word
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [((KeyW+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_o,
                                       // [31:0] min_key, then count, zero pad
  output logic [1:0]                   m_axis_tuser_o   // [1:0] status
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((KeyW + CW + 7) / 8) * 8;

  logic              start, core_ready, core_done;
  res_t              core_res;
  logic [CW-1:0]     core_cnt;
  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q, m_data_d;
  status_e           m_status_q;

  // accept only when the sequencer is idle
  assign s_axis_tready_o = core_ready;
  assign start           = s_axis_tvalid_i & core_ready;

  mhpq_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (action_e'(s_axis_tuser_i)),
    .key_i       (signed'(s_axis_tdata_i)),
    .ready_o     (core_ready),
    .res_ready_i (!m_valid_q || m_axis_tready_i),
    .done_o      (core_done),
    .res_o       (core_res),
    .count_o     (core_cnt)
  );

  // pack the result word: key low, count above it, zeros to the byte boundary
  always_comb begin
    m_data_d                  = '0;
    m_data_d[KeyW-1:0]        = core_res.min_key;
    m_data_d[KeyW+CW-1:KeyW]  = core_cnt;
  end

  // output register; the next item may start while this word waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (core_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      m_data_q   <= m_data_d;
      m_status_q <= core_res.status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;

endmodule

@@ bench/heap_order_checker.sv @@
// Checker for the min-heap queue: keeps its own copy of the heap, predicts one result word
// per accepted input word and compares the result stream field by field.
// Depends on mhpq_pkg; instantiated by min_heap_priority_queue_test.
module heap_order_checker import mhpq_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  input  logic                                          s_axis_tready_i,
  input  logic [KeyW-1:0]                               s_axis_tdata_i,  // [31:0] key
  input  logic [1:0]                                    s_axis_tuser_i,  // [1:0] action
  input  logic                                          m_axis_tvalid_i,
  input  logic                                          m_axis_tready_i,
  input  logic [((KeyW+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_i,
                                                        // [31:0] min_key, count, zero pad
  input  logic [1:0]                                    m_axis_tuser_i,  // [1:0] status
  output int                                            fail_count_o,
  output int                                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CountW = $clog2(CAPACITY + 1);
  localparam int DataW  = ((KeyW + CountW + 7) / 8) * 8;
  localparam int PadW   = DataW - KeyW - CountW;

  typedef struct packed {
    status_e                status;
    logic signed [KeyW-1:0] min_key;
    logic [CountW-1:0]      count;
  } heap_result_t;

  logic signed [KeyW-1:0] heap_keys [CAPACITY];
  int                     heap_size = 0;
  heap_result_t           expected_results [$];
  int                     failures = 0;

  assign fail_count_o = failures;

  // push a node down until neither child is strictly smaller
  function automatic void sink_node(int start);
    int node, left, right, least;
    logic signed [KeyW-1:0] held;
    bit moving;
    node   = start;
    moving = 1'b1;
    while (moving) begin
      left  = 2 * node + 1;
      right = 2 * node + 2;
      least = node;
      if (left < heap_size && heap_keys[left] < heap_keys[node]) least = left;
      if (right < heap_size && heap_keys[right] < heap_keys[least]) least = right;
      if (least == node) begin
        moving = 1'b0;
      end else begin
        held             = heap_keys[node];
        heap_keys[node]  = heap_keys[least];
        heap_keys[least] = held;
        node             = least;
      end
    end
  endfunction

  function automatic heap_result_t apply_word(action_e act, logic signed [KeyW-1:0] key);
    heap_result_t r;
    int pos;
    r.status  = ST_OK;
    r.min_key = '0;
    case (act)
      ACT_INSERT: begin
        if (heap_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = heap_size;
          heap_size++;
          while (pos != 0 && key < heap_keys[(pos - 1) / 2]) begin
            heap_keys[pos] = heap_keys[(pos - 1) / 2];
            pos = (pos - 1) / 2;
          end
          heap_keys[pos] = key;
        end
      end
      ACT_EXTRACT: begin
        if (heap_size == 0) begin
          r.status  = ST_EMPTY;
          r.min_key = -1;
        end else begin
          r.min_key = heap_keys[0];
          heap_size--;
          heap_keys[0] = heap_keys[heap_size];
          sink_node(0);
        end
      end
      ACT_APPEND: begin
        if (heap_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          heap_keys[heap_size] = key;
          heap_size++;
        end
      end
      default: begin
        if (heap_size > 1) begin
          for (int n = (heap_size - 1) / 2; n >= 0; n--) sink_node(n);
        end
      end
    endcase
    r.count = CountW'(heap_size);
    return r;
  endfunction

  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(apply_word(action_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with no prediction pending");
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser_i);
            failures++;
          end
          if (m_axis_tdata_i[KeyW-1:0] !== want.min_key) begin
            $error("min_key mismatch: expected %0d, actual %0d",
                   want.min_key, $signed(m_axis_tdata_i[KeyW-1:0]));
            failures++;
          end
          if (m_axis_tdata_i[KeyW+:CountW] !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d",
                   want.count, m_axis_tdata_i[KeyW+:CountW]);
            failures++;
          end
          if (m_axis_tdata_i[DataW-1-:PadW] !== '0) begin
            $error("pad mismatch: expected 0, actual %0h", m_axis_tdata_i[DataW-1-:PadW]);
            failures++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

@@ bench/min_heap_priority_queue_test.sv @@
// Testbench top for the min-heap queue: drives the input stream and result ready,
// sets the idle phases and prints the verdict.
// Depends on mhpq_pkg, min_heap_priority_queue and heap_order_checker.
module min_heap_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int CAPACITY = 256;
  localparam int CountW   = $clog2(CAPACITY + 1);
  localparam int DataW    = ((KeyW + CountW + 7) / 8) * 8;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  logic [KeyW-1:0]  in_key;
  logic [1:0]       in_action;
  logic             out_valid;
  logic             out_ready;
  logic [DataW-1:0] out_data;
  logic [1:0]       out_status;
  int               fail_count;
  int               pending;

  // idle controls, changed only between words
  bit send_idle  = 1'b0;
  bit recv_stall = 1'b0;
  int idle_pct   = 51;
  // entry count as the stimulus sees it, used only to steer toward full and empty
  int fill_level = 0;

  min_heap_priority_queue #(.CAPACITY(CAPACITY)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_key),
    .s_axis_tuser_i  (in_action),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_status)
  );

  heap_order_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_i (in_ready),
    .s_axis_tdata_i  (in_key),
    .s_axis_tuser_i  (in_action),
    .m_axis_tvalid_i (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_i  (out_data),
    .m_axis_tuser_i  (out_status),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  // result side: ready changes on the falling edge only
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready <= recv_stall ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;
    end
  end

  // keys: half full-range, some in a narrow band so equal keys meet, some at the ends
  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return KeyW'(int'($urandom_range(0, 8)) - 4);
      default: begin
        if ($urandom_range(0, 1)) return 32'h7FFF_FFF0 + $urandom_range(0, 15);
        return 32'h8000_0000 + $urandom_range(0, 15);
      end
    endcase
  endfunction

  function automatic action_e pick_action(int extract_pct);
    int r;
    if ($urandom_range(0, 99) < extract_pct) return ACT_EXTRACT;
    r = $urandom_range(0, 99);
    if (r < 55) return ACT_INSERT;
    if (r < 93) return ACT_APPEND;
    return ACT_BUILD;
  endfunction

  // one word: optional idle gap, then hold valid until the block takes it
  task automatic send_word(action_e act, logic [KeyW-1:0] key);
    while (send_idle && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    in_key    <= key;
    in_action <= act;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    case (act)
      ACT_INSERT, ACT_APPEND: if (fill_level < CAPACITY) fill_level++;
      ACT_EXTRACT:            if (fill_level > 0) fill_level--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    in_valid  = 1'b0;
    in_key    = '0;
    in_action = ACT_INSERT;
    rst_ni    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty extract, build on empty and on one entry, extreme keys,
    // duplicates, raw appends that break the order, then a rebuild
    send_word(ACT_EXTRACT, 32'hFFFF_FFFF);
    send_word(ACT_BUILD,   32'h1234_5678);
    send_word(ACT_INSERT,  32'd5);
    send_word(ACT_BUILD,   32'h0);
    send_word(ACT_EXTRACT, 32'h0);
    send_word(ACT_INSERT,  32'h7FFF_FFFF);
    send_word(ACT_INSERT,  32'h8000_0000);
    send_word(ACT_INSERT,  32'h0);
    send_word(ACT_INSERT,  32'hFFFF_FFFF);
    send_word(ACT_INSERT,  32'hFFFF_FFFF);
    send_word(ACT_INSERT,  32'd1);
    send_word(ACT_EXTRACT, 32'hAAAA_AAAA);
    send_word(ACT_EXTRACT, 32'h5555_5555);
    send_word(ACT_APPEND,  32'd3);
    send_word(ACT_APPEND,  32'hFFFF_FFF9);
    send_word(ACT_APPEND,  32'd100);
    send_word(ACT_APPEND,  32'hFFFF_FFF9);
    send_word(ACT_BUILD,   32'hFFFF_FFFF);
    repeat (5) send_word(ACT_EXTRACT, pick_key());

    // no idling: mixed traffic, with one full pause in the middle
    repeat (100) send_word(pick_action(35), pick_key());
    wait_drained();
    repeat (100) send_word(pick_action(35), pick_key());
    wait_drained();

    // sender gaps: fill to capacity, push a few words into the full store,
    // rebuild the whole store, then shrink
    send_idle = 1'b1;
    while (fill_level < CAPACITY)
      send_word($urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND, pick_key());
    repeat (6) send_word($urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND, pick_key());
    send_word(ACT_BUILD, pick_key());
    repeat (120) send_word(pick_action(60), pick_key());
    wait_drained();

    // receiver stalls only
    send_idle  = 1'b0;
    recv_stall = 1'b1;
    repeat (200) send_word(pick_action(40), pick_key());
    wait_drained();

    // both sides idle at a lighter rate, then drain to empty and extract past it
    send_idle = 1'b1;
    idle_pct  = 30;
    repeat (150) send_word(pick_action(40), pick_key());
    while (fill_level > 0) send_word(ACT_EXTRACT, pick_key());
    repeat (3) send_word(ACT_EXTRACT, pick_key());

    wait_drained();
    repeat (64) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mhpq_pkg.sv
sv/mhpq_core.sv
sv/min_heap_priority_queue.sv
bench/heap_order_checker.sv
bench/min_heap_priority_queue_test.sv
